>>> rtl/core/jst_pkg.sv
// Shared types, codes and keymap ROM for the jog/shuttle event translator.
`timescale 1ns / 1ps

package jst_pkg;

  localparam int KEY_COUNT_DEF      = 15;
  localparam int FIRST_KEY_CODE_DEF = 256;
  localparam int BATCH_MAX_DEF      = 64;

  localparam int MODE_W  = 3;
  localparam int SIZE_W  = 7;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 9;
  localparam int KIND_W  = 3;
  localparam int HELD_W  = 15;
  localparam int KIDX_W  = 4;
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 4;

  // Event modes; codes 4..7 are ignored.
  typedef enum logic [MODE_W-1:0] {
    MODE_SYNC    = 3'd0,
    MODE_SHUTTLE = 3'd1,
    MODE_JOG     = 3'd2,
    MODE_KEY     = 3'd3
  } mode_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_KEY     = 3'd0,
    KIND_BUTTON  = 3'd1,
    KIND_WINDOW  = 3'd2,
    KIND_COMMAND = 3'd3,
    KIND_UNBOUND = 3'd4,
    KIND_RANGE   = 3'd5
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_JOG_KEY_MODE = 1'b0,
    REG_ALT_LAYER    = 1'b1
  } reg_idx_t;

  localparam logic [CFG_W-1:0] JOG_KEY_MODE_RST = 4'd10;
  localparam logic [CFG_W-1:0] ALT_LAYER_RST    = 4'd9;

  // Fixed key and button numbers.
  localparam logic [CODE_W-1:0] KEY_MOD      = 10'd50;
  localparam logic [CODE_W-1:0] KEY_JOG      = 10'd23;
  localparam logic [CODE_W-1:0] BTN_BACK     = 10'd4;
  localparam logic [CODE_W-1:0] BTN_FWD      = 10'd5;
  localparam logic [CODE_W-1:0] BTN_LEFT     = 10'd6;
  localparam logic [CODE_W-1:0] BTN_RIGHT    = 10'd7;
  localparam logic [7:0]        JOG_WRAP_XOR = 8'd254;

  // What one input beat turns into.
  typedef enum logic [2:0] {
    PLAN_NONE,
    PLAN_SHUTTLE,
    PLAN_JOG_KEYS,
    PLAN_JOG_BTN,
    PLAN_SINGLE
  } plan_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic has_more;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] val;
  } map_entry_t;

  // Two-row keymap ROM: alternate row (alt layer held) and base row.
  function automatic map_entry_t keymap(input logic alt, input logic [KIDX_W-1:0] idx);
    map_entry_t e;
    e = '{kind: KIND_KEY, val: '0};
    if (alt) begin
      case (idx)
        4'd6:    e = '{kind: KIND_BUTTON, val: 10'd1};
        default: e = '{kind: KIND_KEY, val: '0};
      endcase
    end else begin
      case (idx)
        4'd0:    e = '{kind: KIND_BUTTON, val: 10'd8};
        4'd1:    e = '{kind: KIND_BUTTON, val: 10'd1};
        4'd2:    e = '{kind: KIND_BUTTON, val: 10'd3};
        4'd3:    e = '{kind: KIND_BUTTON, val: 10'd9};
        4'd10:   e = '{kind: KIND_KEY, val: 10'd37};
        default: e = '{kind: KIND_KEY, val: '0};
      endcase
    end
    return e;
  endfunction

endpackage

>>> rtl/core/jst_if.sv
// Valid/ready channel interfaces for input events and result actions.
`timescale 1ns / 1ps

interface jst_in_if;
  import jst_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic                      first_in_batch;
  logic [SIZE_W-1:0]         batch_size;
  logic [CODE_W-1:0]         code;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, first_in_batch, batch_size, code, value,
                  input ready);
  modport sink   (input valid, mode, first_in_batch, batch_size, code, value,
                  output ready);
endinterface

interface jst_out_if;
  import jst_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] action_code;
  logic              press;
  logic              last;

  modport source (output valid, kind, action_code, press, last, input ready);
  modport sink   (input valid, kind, action_code, press, last, output ready);
endinterface

>>> rtl/core/jst_ctrl.sv
// Controller: takes an event beat, then steps out its results one per slot.
`timescale 1ns / 1ps

module jst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jst_pkg::sts_t sts,
  output jst_pkg::cmd_t cmd
);
  import jst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.has_more) begin
          state_next = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_then_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_EMIT)
    else $error("accept did not enter emit state");

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy && sts.has_more)
    else $error("result loaded over a waiting beat");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("event input ready outside idle state");

endmodule

>>> rtl/core/jst_dp.sv
// Datapath: device state, config registers, result plan and output register.
`timescale 1ns / 1ps

module jst_dp #(
  parameter int KEY_COUNT      = jst_pkg::KEY_COUNT_DEF,
  parameter int FIRST_KEY_CODE = jst_pkg::FIRST_KEY_CODE_DEF,
  parameter int BATCH_MAX      = jst_pkg::BATCH_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [jst_pkg::CFG_W-1:0]          cfg_data,
  input  logic [jst_pkg::MODE_W-1:0]         in_mode,
  input  logic                               in_first,
  input  logic [jst_pkg::SIZE_W-1:0]         in_size,
  input  logic [jst_pkg::CODE_W-1:0]         in_code,
  input  logic signed [jst_pkg::VALUE_W-1:0] in_value,
  input  jst_pkg::cmd_t                      cmd,
  output jst_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jst_pkg::KIND_W-1:0]         out_kind,
  output logic [jst_pkg::CODE_W-1:0]         out_code,
  output logic                               out_press,
  output logic                               out_last
);
  import jst_pkg::*;

  localparam logic [HELD_W-1:0] HELD_MASK  = HELD_W'((32'd1 << KEY_COUNT) - 32'd1);
  localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(FIRST_KEY_CODE);
  localparam logic [CODE_W-1:0] KEY_LIMIT  = CODE_W'(KEY_COUNT);
  localparam logic [SIZE_W-1:0] SIZE_CAP   = SIZE_W'(BATCH_MAX);
  localparam logic [KIDX_W:0]   KIDX_LIMIT = (KIDX_W+1)'(KEY_COUNT);

  // device state
  logic [7:0]        jog_last;
  logic signed [3:0] shuttle_last;
  logic [HELD_W-1:0] held_keys;
  logic              wheel_seen;
  logic              batch_ended;
  logic [CFG_W-1:0]  jog_key_mode_button;
  logic [CFG_W-1:0]  alt_layer_button;

  // registered plan for the current beat
  plan_t             plan_kind;
  logic              plan_dir;
  logic [CODE_W-1:0] plan_btn;
  logic [CNT_W-1:0]  plan_n;
  logic [KIND_W-1:0] plan_rkind;
  logic [CODE_W-1:0] plan_code;
  logic              plan_press;
  logic [CNT_W-1:0]  step;

  // next values worked out from the incoming beat
  logic [7:0]        jog_last_next;
  logic signed [3:0] shuttle_last_next;
  logic [HELD_W-1:0] held_keys_next;
  logic              wheel_seen_next;
  logic              batch_ended_next;
  plan_t             plan_kind_next;
  logic              plan_dir_next;
  logic [CODE_W-1:0] plan_btn_next;
  logic [CNT_W-1:0]  plan_n_next;
  logic [KIND_W-1:0] plan_rkind_next;
  logic [CODE_W-1:0] plan_code_next;
  logic              plan_press_next;

  logic              out_valid_next;

  function automatic logic held_bit(input logic [HELD_W-1:0] h,
                                    input logic [KIDX_W-1:0] idx);
    logic [HELD_W:0] hx;
    hx = {1'b0, h};
    return ({1'b0, idx} < KIDX_LIMIT) && hx[idx];
  endfunction

  // combinational views of the beat
  logic signed [3:0] shut_pos;
  logic [2:0]        shut_mag;
  logic [7:0]        jog_byte;
  logic [7:0]        jog_diff;
  logic [SIZE_W-1:0] size_sat;
  logic              size_small;
  logic [CODE_W-1:0] key_off;
  logic              key_ok;
  logic [KIDX_W-1:0] key_idx;
  logic              key_press;
  logic [HELD_W-1:0] held_upd;
  map_entry_t        alt_e;
  map_entry_t        sel_e;
  logic              jog_step;
  logic              jog_dir;

  always_comb begin
    if (in_value > 9'sd7) begin
      shut_pos = 4'sd7;
    end else if (in_value < -9'sd7) begin
      shut_pos = -4'sd7;
    end else begin
      shut_pos = in_value[3:0];
    end
    shut_mag   = shut_pos[3] ? 3'(-shut_pos) : shut_pos[2:0];
    jog_byte   = in_value[7:0];
    jog_diff   = jog_byte ^ jog_last;
    size_sat   = (in_size > SIZE_CAP) ? SIZE_CAP : in_size;
    size_small = size_sat < SIZE_W'(3);
    key_off    = in_code - FIRST_CODE;
    key_ok     = (in_code >= FIRST_CODE) && (key_off < KEY_LIMIT);
    key_idx    = key_off[KIDX_W-1:0];
    key_press  = in_value != '0;
    held_upd   = (key_press ? (held_keys | (HELD_W'(1) << key_idx))
                            : (held_keys ^ (HELD_W'(1) << key_idx))) & HELD_MASK;
    alt_e      = keymap(1'b1, key_idx);
    sel_e      = (held_bit(held_upd, alt_layer_button) && (alt_e != '0))
                 ? alt_e : keymap(1'b0, key_idx);
    jog_step   = jog_diff[0] || (jog_diff == JOG_WRAP_XOR);
    jog_dir    = jog_diff[0] ? (jog_byte > jog_last) : (jog_byte < jog_last);
  end

  always_comb begin
    jog_last_next     = jog_last;
    shuttle_last_next = shuttle_last;
    held_keys_next    = held_keys;
    wheel_seen_next   = wheel_seen && !in_first;
    batch_ended_next  = batch_ended && !in_first;
    plan_kind_next    = PLAN_NONE;
    plan_dir_next     = jog_dir;
    plan_btn_next     = BTN_FWD;
    plan_n_next       = '0;
    plan_rkind_next   = KIND_RANGE;
    plan_code_next    = in_code;
    plan_press_next   = key_press;
    if (!batch_ended_next) begin
      case (in_mode)
        MODE_SYNC: batch_ended_next = 1'b1;
        MODE_SHUTTLE: begin
          wheel_seen_next = 1'b1;
          if (shut_pos != shuttle_last) begin
            shuttle_last_next = shut_pos;
            if (shut_pos != 4'sd0) begin
              plan_kind_next = PLAN_SHUTTLE;
              plan_btn_next  = shut_pos[3] ? BTN_BACK : BTN_FWD;
              plan_n_next    = {shut_mag, 1'b0};
            end
          end
        end
        MODE_JOG: begin
          if (jog_diff == '0) begin
            if (!wheel_seen_next && shuttle_last[0] && size_small) begin
              shuttle_last_next = 4'sd0;
            end
          end else begin
            jog_last_next = jog_byte;
            if (jog_step) begin
              if (held_bit(held_keys, jog_key_mode_button)) begin
                plan_kind_next = PLAN_JOG_KEYS;
                plan_n_next    = jog_dir ? CNT_W'(2) : CNT_W'(4);
              end else begin
                plan_kind_next = PLAN_JOG_BTN;
                plan_n_next    = CNT_W'(2);
                if (held_bit(held_keys, alt_layer_button)) begin
                  plan_btn_next = jog_dir ? BTN_RIGHT : BTN_LEFT;
                end else begin
                  plan_btn_next = jog_dir ? BTN_FWD : BTN_BACK;
                end
              end
            end
          end
        end
        MODE_KEY: begin
          plan_kind_next = PLAN_SINGLE;
          plan_n_next    = CNT_W'(1);
          if (key_ok) begin
            held_keys_next = held_upd;
            if (sel_e == '0) begin
              plan_rkind_next = KIND_UNBOUND;
              plan_code_next  = CODE_W'(key_idx);
            end else begin
              plan_rkind_next = sel_e.kind;
              plan_code_next  = sel_e.val;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jog_last            <= '0;
      shuttle_last        <= '0;
      held_keys           <= '0;
      wheel_seen          <= 1'b0;
      batch_ended         <= 1'b0;
      jog_key_mode_button <= JOG_KEY_MODE_RST;
      alt_layer_button    <= ALT_LAYER_RST;
      plan_n              <= '0;
      step                <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_JOG_KEY_MODE: jog_key_mode_button <= cfg_data;
          REG_ALT_LAYER:    alt_layer_button    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        jog_last     <= jog_last_next;
        shuttle_last <= shuttle_last_next;
        held_keys    <= held_keys_next;
        wheel_seen   <= wheel_seen_next;
        batch_ended  <= batch_ended_next;
        plan_n       <= plan_n_next;
        step         <= '0;
      end else if (cmd.emit) begin
        step <= step + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      plan_kind  <= plan_kind_next;
      plan_dir   <= plan_dir_next;
      plan_btn   <= plan_btn_next;
      plan_rkind <= plan_rkind_next;
      plan_code  <= plan_code_next;
      plan_press <= plan_press_next;
    end
  end

  // result for the current step
  logic [KIND_W-1:0] res_kind;
  logic [CODE_W-1:0] res_code;
  logic              res_press;

  always_comb begin
    res_kind  = KIND_BUTTON;
    res_code  = plan_btn;
    res_press = !step[0];
    case (plan_kind)
      PLAN_JOG_KEYS: begin
        res_kind = KIND_KEY;
        if (plan_dir) begin
          res_code  = KEY_JOG;
          res_press = !step[0];
        end else begin
          // modifier wraps the jog key: mod down, jog down, jog up, mod up
          res_code  = (step[0] ^ step[1]) ? KEY_JOG : KEY_MOD;
          res_press = !step[1];
        end
      end
      PLAN_SINGLE: begin
        res_kind  = plan_rkind;
        res_code  = plan_code;
        res_press = plan_press;
      end
      default: ;
    endcase
  end

  assign sts.has_more = step != plan_n;
  assign sts.out_busy = out_valid && !out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= res_kind;
      out_code  <= res_code;
      out_press <= res_press;
      out_last  <= step == plan_n - CNT_W'(1);
    end
  end

  a_held_masked: assert property (@(posedge clk) disable iff (rst)
    (held_keys & ~HELD_MASK) == '0)
    else $error("held key bit set beyond key count");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> step <= plan_n)
    else $error("result step ran past plan");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
    else $error("waiting result changed");

endmodule

>>> rtl/core/jog_shuttle_event_translator.sv
// Top level of the jog/shuttle event translator.
//
// evt (sink): one device event per beat - mode, first_in_batch, batch_size,
//   code, value. act (source): one press/release action per beat, with last
//   set on the final action caused by an event.
// cfg: cfg_we writes cfg_data into register cfg_index (0 jog key mode
//   button, 1 alt layer button); write only while idle.
// Output: the first action is loaded into the output register by the emit
//   state after the evt beat is accepted. Actions then follow one per cycle
//   while act is ready, from a single output register.
// Events: an event causing n actions (0..14) occupies the controller until
//   its actions are loaded; evt.ready is high only while the controller is
//   idle, not while the emit state machine steps through the action list.
// Receiver stall: act holds its beat; the controller waits and no further
//   action is loaded. A new event may still be taken while the final action
//   waits on act.
// Reset (rst, synchronous): clears jog, shuttle, held keys and batch flags,
//   loads config defaults (10 and 9) and drops any pending action.
`timescale 1ns / 1ps

module jog_shuttle_event_translator #(
  parameter int KEY_COUNT      = jst_pkg::KEY_COUNT_DEF,
  parameter int FIRST_KEY_CODE = jst_pkg::FIRST_KEY_CODE_DEF,
  parameter int BATCH_MAX      = jst_pkg::BATCH_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [jst_pkg::CFG_W-1:0] cfg_data,
  jst_in_if.sink                    evt,
  jst_out_if.source                 act
);
  import jst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  jst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (evt.valid),
    .in_ready (evt.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state, plan and output register
  jst_dp #(
    .KEY_COUNT      (KEY_COUNT),
    .FIRST_KEY_CODE (FIRST_KEY_CODE),
    .BATCH_MAX      (BATCH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (evt.mode),
    .in_first  (evt.first_in_batch),
    .in_size   (evt.batch_size),
    .in_code   (evt.code),
    .in_value  (evt.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (act.valid),
    .out_ready (act.ready),
    .out_kind  (act.kind),
    .out_code  (act.action_code),
    .out_press (act.press),
    .out_last  (act.last)
  );

endmodule
